// ===== hw/rtl/irc_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and constants for the IRC message tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  // Default limit on the number of parameters in one message.
  localparam int MaxParamsDef = 15;

  // Parse phase codes.
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_PREFIX   = 3'd1;
  localparam logic [2:0] PH_COMMAND  = 3'd2;
  localparam logic [2:0] PH_PARAMS   = 3'd3;
  localparam logic [2:0] PH_TRAILING = 3'd4;
  localparam logic [2:0] PH_STOPPED  = 3'd5;

  // Field kind codes.
  localparam logic [1:0] KIND_PREFIX   = 2'd0;
  localparam logic [1:0] KIND_COMMAND  = 2'd1;
  localparam logic [1:0] KIND_MIDDLE   = 2'd2;
  localparam logic [1:0] KIND_TRAILING = 2'd3;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One output beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [1:0] field_kind;
    logic [3:0] param_index;
    logic       token_start;
    logic       msg_done;
    logic [3:0] params_found;
  } res_t;

endpackage

// ===== hw/rtl/irc_message_tokenizer.sv =====
// ----------------------------------------------------------------------------
// irc_message_tokenizer
// Streaming tokenizer that tags each message byte as prefix, command, middle
// or trailing parameter.
// ----------------------------------------------------------------------------
// The block takes one message byte per beat, with msg_end set on the last
// byte, and returns at most one beat per input byte: a beat appears when the
// byte belongs to a token or when it is the last byte of the message. A leading
// colon opens the prefix and is dropped; spaces separate tokens; a parameter
// that starts with a colon, or the parameter in the last allowed slot, is the
// trailing parameter and runs to CR or LF. A NUL byte, or CR/LF among the
// parameters, ends the message text, and the remaining bytes up to msg_end are
// dropped. The beat for the last byte carries msg_done and the number of
// parameters found, and the parser then returns to its start state. The phase
// update is a single level of logic between the parser state registers and the
// output register, so a new byte can be accepted on every clock while in_ready
// is high. Results leave through an output register backed by a one-entry skid
// register, so the input keeps accepting while one finished beat waits for
// out_ready; in_ready drops only when both are full. An accepted beat goes into
// the output register, or into the skid register while the output waits.
// ----------------------------------------------------------------------------
module irc_message_tokenizer import irc_tok_pkg::*; #(
  parameter int MAX_PARAMS = MaxParamsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       msg_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       data_valid,
  output logic [1:0] field_kind,
  output logic [3:0] param_index,
  output logic       token_start,
  output logic       msg_done,
  output logic [3:0] params_found
);

  // Once this many parameters are seen, the next one is trailing.
  localparam logic [3:0] LastMiddle = 4'(MAX_PARAMS - 1);

  // Parser state.
  logic [2:0] phase, phase_next;
  logic [3:0] params_seen, params_next;
  logic       token_open, open_next;

  // Output register and skid register.
  res_t out_res, skid_res, res;
  logic skid_valid;
  logic res_valid;
  logic in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  // Per-byte tokenizer step.
  always_comb begin
    logic [2:0] ph;
    logic       consumed;
    ph           = phase;
    consumed     = 1'b0;
    phase_next   = phase;
    params_next  = params_seen;
    open_next    = token_open;
    res          = '0;
    if (in_byte == CH_NUL) begin
      phase_next = PH_STOPPED;
    end else begin
      // At message start the first byte decides between prefix and command.
      if (phase == PH_START) begin
        open_next = 1'b0;
        if (in_byte == CH_COLON) begin
          ph       = PH_PREFIX;
          consumed = 1'b1;
        end else begin
          ph = PH_COMMAND;
        end
      end
      phase_next = ph;
      if (!consumed) begin
        unique case (ph)
          PH_PREFIX: begin
            if (in_byte == CH_SPACE) begin
              phase_next = PH_COMMAND;
              open_next  = 1'b0;
            end else begin
              res.data_valid  = 1'b1;
              res.field_kind  = KIND_PREFIX;
              res.token_start = !open_next;
              open_next       = 1'b1;
            end
          end
          PH_COMMAND: begin
            if (in_byte == CH_SPACE) begin
              // Spaces before the command are skipped.
              if (open_next) begin
                phase_next = PH_PARAMS;
                open_next  = 1'b0;
              end
            end else begin
              res.data_valid  = 1'b1;
              res.field_kind  = KIND_COMMAND;
              res.token_start = !open_next;
              open_next       = 1'b1;
            end
          end
          PH_PARAMS: begin
            if (in_byte == CH_CR || in_byte == CH_LF) begin
              phase_next = PH_STOPPED;
            end else if (token_open) begin
              if (in_byte == CH_SPACE) begin
                open_next = 1'b0;
              end else begin
                res.data_valid  = 1'b1;
                res.field_kind  = KIND_MIDDLE;
                res.param_index = params_seen - 4'd1;
              end
            end else if (in_byte != CH_SPACE) begin
              res.data_valid  = 1'b1;
              res.token_start = 1'b1;
              res.param_index = params_seen;
              if (in_byte == CH_COLON || params_seen >= LastMiddle) begin
                res.field_kind = KIND_TRAILING;
                phase_next     = PH_TRAILING;
              end else begin
                res.field_kind = KIND_MIDDLE;
                open_next      = 1'b1;
              end
              params_next = params_seen + 4'd1;
            end
          end
          PH_TRAILING: begin
            if (in_byte == CH_CR || in_byte == CH_LF) begin
              phase_next = PH_STOPPED;
            end else begin
              res.data_valid  = 1'b1;
              res.field_kind  = KIND_TRAILING;
              res.param_index = params_seen - 4'd1;
            end
          end
          default: begin
            // Stopped and unused codes drop the byte.
          end
        endcase
      end
    end
    if (res.data_valid) begin
      res.data_byte = in_byte;
    end
    res.msg_done = msg_end;
    if (msg_end) begin
      res.params_found = params_next;
    end
    res_valid = res.data_valid || msg_end;
  end

  // Parser state registers; the last byte returns the parser to its start.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      params_seen <= '0;
      token_open  <= 1'b0;
    end else if (in_fire) begin
      if (msg_end) begin
        phase       <= PH_START;
        params_seen <= '0;
        token_open  <= 1'b0;
      end else begin
        phase       <= phase_next;
        params_seen <= params_next;
        token_open  <= open_next;
      end
    end
  end

  // Output register with skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_fire) begin
        out_res <= res;
      end
    end else if (in_fire) begin
      skid_res <= res;
    end
  end

  assign data_byte    = out_res.data_byte;
  assign data_valid   = out_res.data_valid;
  assign field_kind   = out_res.field_kind;
  assign param_index  = out_res.param_index;
  assign token_start  = out_res.token_start;
  assign msg_done     = out_res.msg_done;
  assign params_found = out_res.params_found;

`ifndef ASSERT_OFF
  // The skid register only fills behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A beat without a token byte exists only to close a message.
  a_empty_beat_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !data_valid) |-> msg_done)
    else $error("empty beat without msg_done");

  // Fields of a beat without a token byte stay cleared.
  a_empty_beat_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !data_valid) |->
      (field_kind == KIND_PREFIX && !token_start && param_index == 4'd0))
    else $error("stray fields on empty beat");

  // The parameter count never exceeds the parameter limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && msg_done) |-> (params_found <= 4'(MAX_PARAMS)))
    else $error("parameter count above limit");
`endif

endmodule

// ===== verif/irc_message_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// irc_message_tokenizer_test
// Self-checking bench for the streaming IRC message tokenizer.
// ----------------------------------------------------------------------------
// Message bytes go in over a valid/ready channel. Each accepted byte is fed to
// a tokenizer model kept in this bench, and every beat that the model says
// must come out waits in a queue. Beats at the output are compared field by
// field against the oldest expected beat. A short directed table opens the run:
// the dropped leading colon, prefix bytes, extreme byte values, NUL, CR and LF
// in the start, command and parameter phases, and the empty prefix. After that
// come random messages: mostly well-formed ones with random content (some with
// long parameter lists that reach the trailing slot), plus damaged messages and
// raw noise. Both sides idle in random bursts, and the tail runs at full rate.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_test;
  import irc_tok_pkg::*;

  localparam int MaxParams     = MaxParamsDef;
  localparam int ByteBudget    = 1350;  // message bytes to send in total
  localparam int CalmTail      = 120;   // last bytes sent with no idling
  localparam int DrainCycles   = 16;    // settle time after the last beat
  localparam int WatchdogLimit = 4000;  // cycles with no beat on either side

  // One byte of message text together with its end flag.
  typedef struct packed {
    logic       e;
    logic [7:0] b;
  } text_beat_t;

  // One row of the directed table. When typed is set, the expected outcome is
  // written in the row (t_has says whether a beat comes out at all);
  // otherwise the tokenizer model supplies it.
  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    logic       t_has;
    res_t       t_res;
  } stim_row_t;

  localparam int NumRows = 26;
  localparam stim_row_t DirRows [NumRows] = '{
    // Prefix with the leading colon dropped, then the extreme byte value.
    '{CH_COLON, 1'b0, 1'b1, 1'b0, '0},
    '{8'h6E,    1'b0, 1'b1, 1'b1, '{8'h6E, 1'b1, KIND_PREFIX, 4'd0, 1'b1, 1'b0, 4'd0}},
    '{8'hFF,    1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, KIND_PREFIX, 4'd0, 1'b0, 1'b0, 4'd0}},
    '{CH_SPACE, 1'b0, 1'b1, 1'b0, '0},
    // Command, a middle parameter with a colon inside, a trailing one with a
    // space inside, then CR stops the text and the byte after it is dropped.
    '{8'h50,    1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{8'h61,    1'b0, 1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_COLON, 1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_CR,    1'b0, 1'b0, 1'b0, '0},
    '{8'h7A,    1'b1, 1'b0, 1'b0, '0},
    // A message that is a single NUL: only the end beat, no parameters.
    '{CH_NUL,   1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, KIND_PREFIX, 4'd0, 1'b0, 1'b1, 4'd0}},
    // Empty prefix, then LF inside the command is an ordinary byte.
    '{CH_COLON, 1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_LF,    1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b1, 1'b0, 1'b0, '0},
    // Leading space before the command, LF among the parameters ends it.
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{8'h51,    1'b0, 1'b0, 1'b0, '0},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, '0},
    '{CH_LF,    1'b1, 1'b0, 1'b0, '0},
    // NUL in the middle of the command drops the rest of the message.
    '{8'h01,    1'b0, 1'b0, 1'b0, '0},
    '{CH_NUL,   1'b0, 1'b0, 1'b0, '0},
    '{8'h78,    1'b1, 1'b0, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       msg_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       data_valid;
  logic [1:0] field_kind;
  logic [3:0] param_index;
  logic       token_start;
  logic       msg_done;
  logic [3:0] params_found;

  // Tokenizer model state: parse phase, parameters started so far, and
  // whether a token of the current phase has begun.
  logic [2:0] parse_phase = PH_START;
  logic [3:0] params_open = 4'd0;
  logic       in_token = 1'b0;

  res_t       tokens_due[$];   // beats the block still owes, oldest first
  text_beat_t msg_bytes[$];    // the random message being sent
  int         bytes_sent = 0;  // bytes accepted by the block so far
  int         faults = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  int         gap_pct = 25;    // chance of an input gap before a byte
  int         stall_pct = 25;  // chance of an output stall burst
  bit         calm = 1'b0;     // no idling at all while set

  irc_message_tokenizer #(.MAX_PARAMS(MaxParams)) dut (
    .clk, .rst,
    .in_valid, .in_ready, .in_byte, .msg_end,
    .out_valid, .out_ready,
    .data_byte, .data_valid, .field_kind, .param_index,
    .token_start, .msg_done, .params_found
  );

  always #6 clk = ~clk;

  // Advances the tokenizer model by one byte. has_beat tells whether the
  // block must answer this byte, and beat holds the answer.
  function automatic void tokenize_byte(input logic [7:0] b, input logic last,
                                        output logic has_beat, output res_t beat);
    logic       kept;
    logic       colon_eaten;
    logic [1:0] kind;
    logic [3:0] idx;
    logic       first;
    kept = 1'b0;
    colon_eaten = 1'b0;
    kind = KIND_PREFIX;
    idx = 4'd0;
    first = 1'b0;
    if (b == CH_NUL) begin
      // NUL ends the text in any phase.
      parse_phase = PH_STOPPED;
    end else begin
      if (parse_phase == PH_START) begin
        in_token = 1'b0;
        if (b == CH_COLON) begin
          parse_phase = PH_PREFIX;
          colon_eaten = 1'b1;
        end else begin
          parse_phase = PH_COMMAND;
        end
      end
      if (!colon_eaten) begin
        case (parse_phase)
          PH_PREFIX: begin
            if (b == CH_SPACE) begin
              parse_phase = PH_COMMAND;
              in_token = 1'b0;
            end else begin
              kept = 1'b1;
              kind = KIND_PREFIX;
              first = !in_token;
              in_token = 1'b1;
            end
          end
          PH_COMMAND: begin
            // Spaces before the command are skipped; one after it ends it.
            if (b == CH_SPACE) begin
              if (in_token) begin
                parse_phase = PH_PARAMS;
                in_token = 1'b0;
              end
            end else begin
              kept = 1'b1;
              kind = KIND_COMMAND;
              first = !in_token;
              in_token = 1'b1;
            end
          end
          PH_PARAMS: begin
            if (b == CH_CR || b == CH_LF) begin
              parse_phase = PH_STOPPED;
            end else if (in_token) begin
              if (b == CH_SPACE) begin
                in_token = 1'b0;
              end else begin
                kept = 1'b1;
                kind = KIND_MIDDLE;
                idx = params_open - 4'd1;
              end
            end else if (b != CH_SPACE) begin
              // A new parameter: trailing if it opens with a colon or takes
              // the last allowed slot, middle otherwise.
              kept = 1'b1;
              first = 1'b1;
              idx = params_open;
              if (b == CH_COLON || params_open >= 4'(MaxParams - 1)) begin
                kind = KIND_TRAILING;
                parse_phase = PH_TRAILING;
              end else begin
                kind = KIND_MIDDLE;
                in_token = 1'b1;
              end
              params_open = params_open + 4'd1;
            end
          end
          PH_TRAILING: begin
            if (b == CH_CR || b == CH_LF) begin
              parse_phase = PH_STOPPED;
            end else begin
              kept = 1'b1;
              kind = KIND_TRAILING;
              idx = params_open - 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
    has_beat = kept || last;
    beat.data_byte    = kept ? b : 8'h00;
    beat.data_valid   = kept;
    beat.field_kind   = kept ? kind : KIND_PREFIX;
    beat.param_index  = kept ? idx : 4'd0;
    beat.token_start  = kept ? first : 1'b0;
    beat.msg_done     = last;
    beat.params_found = last ? params_open : 4'd0;
    if (last) begin
      parse_phase = PH_START;
      params_open = 4'd0;
      in_token = 1'b0;
    end
  endfunction

  function automatic string describe(input res_t r);
    return $sformatf("byte %02h valid %0d kind %0d idx %0d start %0d done %0d count %0d",
                     r.data_byte, r.data_valid, r.field_kind, r.param_index,
                     r.token_start, r.msg_done, r.params_found);
  endfunction

  function automatic void report_fault(input string what, input res_t want, input res_t got);
    faults++;
    if (faults <= 10) begin
      $display("%s\n  expected %s\n  actual   %s", what, describe(want), describe(got));
    end
  endfunction

  // A random token byte: mostly letters, sometimes any byte that cannot end
  // or split a token. colon_ok lets a colon through.
  function automatic logic [7:0] text_byte(input bit colon_ok);
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(8'h41, 8'h7A));
    end while (c == CH_SPACE || c == CH_CR || c == CH_LF || (!colon_ok && c == CH_COLON));
    return c;
  endfunction

  // Fills msg_bytes with one random message. Most are well-formed with random
  // content; some are then damaged (cut short, a byte overwritten, a NUL
  // dropped in); the rest are raw noise over the full byte range.
  function automatic void build_message();
    int         pick;
    int         np;
    int         pos;
    int         tail;
    text_beat_t nul_beat;
    msg_bytes.delete();
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 20)) msg_bytes.push_back({1'b0, 8'($urandom_range(255))});
    end else begin
      if ($urandom_range(1) == 1) begin
        msg_bytes.push_back({1'b0, CH_COLON});
        repeat ($urandom_range(0, 6)) msg_bytes.push_back({1'b0, text_byte(1'b1)});
        repeat ($urandom_range(1, 2)) msg_bytes.push_back({1'b0, CH_SPACE});
      end else begin
        repeat ($urandom_range(0, 3) / 2) msg_bytes.push_back({1'b0, CH_SPACE});
      end
      // The command: its first byte must not look like a prefix.
      msg_bytes.push_back({1'b0, text_byte(1'b0)});
      repeat ($urandom_range(0, 4)) msg_bytes.push_back({1'b0, text_byte(1'b1)});
      // Now and then a long list that runs into the last parameter slot.
      np = ($urandom_range(7) == 0) ? $urandom_range(12, 17) : $urandom_range(0, 4);
      for (int i = 0; i < np; i++) begin
        repeat ($urandom_range(1, 3)) msg_bytes.push_back({1'b0, CH_SPACE});
        if (i == np - 1 && $urandom_range(1) == 1) begin
          msg_bytes.push_back({1'b0, CH_COLON});
          repeat ($urandom_range(0, 6)) begin
            msg_bytes.push_back({1'b0, ($urandom_range(3) == 0) ? CH_SPACE : text_byte(1'b1)});
          end
        end else begin
          msg_bytes.push_back({1'b0, text_byte(1'b0)});
          repeat ($urandom_range(0, 3)) msg_bytes.push_back({1'b0, text_byte(1'b1)});
        end
      end
      tail = $urandom_range(9);
      if (tail < 6) begin
        msg_bytes.push_back({1'b0, CH_CR});
        msg_bytes.push_back({1'b0, CH_LF});
      end else if (tail == 9) begin
        msg_bytes.push_back({1'b0, CH_CR});
        repeat ($urandom_range(1, 3)) msg_bytes.push_back({1'b0, 8'($urandom_range(255))});
      end
      if (pick < 30) begin
        pos = $urandom_range(0, msg_bytes.size() - 1);
        case ($urandom_range(2))
          0: while (msg_bytes.size() > pos + 1) void'(msg_bytes.pop_back());
          1: msg_bytes[pos].b = 8'($urandom_range(255));
          default: begin
            nul_beat = {1'b0, CH_NUL};
            msg_bytes.insert(pos, nul_beat);
          end
        endcase
      end
    end
    msg_bytes[msg_bytes.size() - 1].e = 1'b1;
  endfunction

  // Offers one byte, waits for the handshake, and books the beat it causes.
  // A random input gap may come first, never while valid is up.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic t_has, input res_t t_res);
    logic has_beat;
    res_t beat;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_byte <= b;
    msg_end <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    tokenize_byte(b, last, has_beat, beat);
    if (typed) begin
      has_beat = t_has;
      beat = t_res;
    end
    if (has_beat) tokens_due.push_back(beat);
  endtask

  // Output side: random stall bursts, none while calm is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted output beat must match the oldest booked one.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && out_ready) begin
      got = {data_byte, data_valid, field_kind, param_index, token_start, msg_done,
             params_found};
      if (tokens_due.size() == 0) begin
        report_fault("output beat with nothing expected", '0, got);
      end else begin
        want = tokens_due.pop_front();
        if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
            got.field_kind !== want.field_kind || got.param_index !== want.param_index ||
            got.token_start !== want.token_start || got.msg_done !== want.msg_done ||
            got.params_found !== want.params_found) begin
          report_fault("output beat mismatch", want, got);
        end
      end
    end
  end

  // The watchdog trips when neither side has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DirRows[i]) begin
      send_byte(DirRows[i].b, DirRows[i].e, DirRows[i].typed, DirRows[i].t_has,
                DirRows[i].t_res);
    end

    // Random messages. Idling changes from one message to the next, so some
    // stretches run with no gaps at all, and the tail runs at full rate.
    while (bytes_sent < ByteBudget) begin
      case ($urandom_range(3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 40;
        default: gap_pct = 20;
      endcase
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 40;
        default: stall_pct = 20;
      endcase
      calm = (bytes_sent > ByteBudget - CalmTail);
      build_message();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i].b, msg_bytes[i].e, 1'b0, 1'b0, '0);
    end
    in_valid <= 1'b0;
    calm = 1'b1;

    // Drain: wait for every booked beat, then watch a little longer for
    // anything extra.
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/irc_tok_pkg.sv
hw/rtl/irc_message_tokenizer.sv
verif/irc_message_tokenizer_test.sv
